// ===== design/assert_macros.svh =====
// Assertion macros used by the matrix inverse design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define MI4_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define MI4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mi4_pkg.sv =====
// Types, tables and helpers of the 4x4 matrix inverse.
package mi4_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CF_FETCH,
        ST_CF_LOAD,
        ST_MUL,
        ST_ACC,
        ST_PASS,
        ST_ADD,
        ST_DT_FETCH,
        ST_DT_LOAD,
        ST_DT_FIN,
        ST_OUT_FETCH,
        ST_DV_START,
        ST_DV_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_STEP,
        DV_RND
    } t_dv_state;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    localparam logic [3:0] LAST_CELL = 4'd15;
    localparam logic [3:0] LAST_DET  = 4'd3;
    localparam logic [2:0] LAST_TERM = 3'd5;
    localparam logic [2:0] NEG_TERM  = 3'd3;
    localparam logic [1:0] LAST_FAC  = 2'd2;
    localparam logic [3:0] RUN_INDEX = 4'd15;

    // Minor column picked for each row of each of the six 3x3 terms.
    localparam logic [1:0] OPND_COL [6][3] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd1}
    };

    // Row-major index of factor fac of term term in the minor of entry ent.
    function automatic logic [3:0] cof_opnd(input logic [3:0] ent,
                                            input logic [2:0] term,
                                            input logic [1:0] fac);
        logic [1:0] pc;
        logic [1:0] row;
        logic [1:0] col;
        pc  = OPND_COL[term][fac];
        row = (fac < ent[3:2]) ? fac : fac + 2'd1;
        col = (pc < ent[1:0]) ? pc : pc + 2'd1;
        return {row, col};
    endfunction

endpackage

// ===== design/mi4_if.sv =====
// Handshake channels for matrix elements in and inverse elements out.
interface mi4_in_if #(parameter int ELEM_WIDTH = 32) ();
    logic                  valid;
    logic                  ready;
    logic [3:0]            elem_index;
    logic [ELEM_WIDTH-1:0] elem_value;

    modport source (output valid, output elem_index, output elem_value, input ready);
    modport sink (input valid, input elem_index, input elem_value, output ready);
endinterface

interface mi4_out_if #(parameter int ELEM_WIDTH = 32) ();
    logic                  valid;
    logic                  ready;
    logic [3:0]            out_index;
    logic [ELEM_WIDTH-1:0] out_value;
    logic                  singular;
    logic                  saturated;
    logic                  last;

    modport source (output valid, output out_index, output out_value, output singular,
                    output saturated, output last, input ready);
    modport sink (input valid, input out_index, input out_value, input singular,
                  input saturated, input last, output ready);
endinterface

// ===== design/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse by adjugate: element store, cofactor engine, divide and output.
// Loading: one element beat per cycle while idle; index 15 starts a run.
// Run: cofactor and determinant work (16 cofactors, then the determinant, on the one
//   shared multiplier), then each inverse element in turn from the bit-serial divider,
//   or the stored element passed through when singular.
// Inputs are refused during a run; the output register holds each result beat.
// Synchronous active-low reset clears control only; the element store is not cleared.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mi4_in_if.sink     i_elem,
    mi4_out_if.source  o_res
);
    `include "assert_macros.svh"

    // Full-width sizes: element, cofactor (sum of six triple products),
    // determinant, running product magnitude, and chunks of a product.
    localparam int W   = ELEM_WIDTH;
    localparam int CW  = 3 * W + 3;
    localparam int DW  = 4 * W + 5;
    localparam int XW  = CW + W;
    localparam int NCH = (CW + W - 1) / W;
    localparam int CHW = $clog2(NCH);

    // Element store and cofactor store: one write, one registered read each.
    logic [W-1:0]    r_store [16];
    logic [CW-1:0]   r_cof   [16];
    logic [W-1:0]    r_sq;
    logic [CW-1:0]   r_cq;
    logic [3:0]      st_raddr;
    logic [3:0]      cf_raddr;
    logic            st_we;
    logic            cf_we;
    logic [CW-1:0]   cf_wdata;

    t_state          r_state, n_state;
    logic [3:0]      r_cell, n_cell;     // cofactor being built (row, col)
    logic [2:0]      r_term, n_term;     // term of the 3x3 minor
    logic [1:0]      r_fac, n_fac;       // factor within the term
    logic [3:0]      r_k, n_k;           // determinant column, then output index
    logic [CHW-1:0]  r_chunk, n_chunk;
    logic [CHW:0]    r_nch, n_nch;
    logic            r_det, n_det;
    logic [XW-1:0]   r_prod, n_prod;
    logic [XW-1:0]   r_nxt, n_nxt;
    logic [2*W-1:0]  r_pp, n_pp;
    logic            r_sign, n_sign;
    logic [DW-1:0]   r_acc, n_acc;
    logic            r_dz, n_dz;
    logic            r_dneg, n_dneg;
    logic [DW-1:0]   r_dmag, n_dmag;

    // finished element waiting for the output register
    logic [W-1:0]    r_pval, n_pval;
    logic            r_psing, n_psing;
    logic            r_psat, n_psat;

    logic            r_ov, n_ov;
    logic [3:0]      r_oidx, n_oidx;
    logic [W-1:0]    r_oval, n_oval;
    logic            r_osing, n_osing;
    logic            r_osat, n_osat;
    logic            r_olast, n_olast;

    logic            in_acc;
    logic [W-1:0]    emag;
    logic [W-1:0]    chunk_w;
    logic [CW-1:0]   cmag;
    logic [DW-1:0]   sum;
    logic            div_start;
    t_div_stat       div_stat;
    logic [W-1:0]    div_value;

    assign i_elem.ready    = (r_state == ST_IDLE);
    assign in_acc          = i_elem.valid && i_elem.ready;
    assign o_res.valid     = r_ov;
    assign o_res.out_index = r_oidx;
    assign o_res.out_value = r_oval;
    assign o_res.singular  = r_osing;
    assign o_res.saturated = r_osat;
    assign o_res.last      = r_olast;

    // Operand addresses: minor elements while building cofactors, then
    // first row and stored elements by r_k; the adjugate is read transposed.
    always_comb begin
        st_raddr = r_det ? r_k : cof_opnd(r_cell, r_term, r_fac);
        if (r_state == ST_OUT_FETCH || r_state == ST_DV_START) begin
            cf_raddr = {r_k[1:0], r_k[3:2]};
        end else begin
            cf_raddr = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[i_elem.elem_index] <= i_elem.elem_value;
        end
        r_sq <= r_store[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cf_we) begin
            r_cof[r_cell] <= cf_wdata;
        end
        r_cq <= r_cof[cf_raddr];
    end

    mi4_divider #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (r_cq),
        .i_den     (r_dmag),
        .i_den_neg (r_dneg),
        .o_stat    (div_stat),
        .o_value   (div_value)
    );

    always_comb begin
        emag    = r_sq[W-1] ? W'(-r_sq) : r_sq;
        chunk_w = W'(r_prod >> (r_chunk * W));
        cmag    = r_cq[CW-1] ? CW'(-r_cq) : r_cq;
        sum     = r_sign ? (r_acc - DW'(r_prod)) : (r_acc + DW'(r_prod));

        n_state   = r_state;
        n_cell    = r_cell;
        n_term    = r_term;
        n_fac     = r_fac;
        n_k       = r_k;
        n_chunk   = r_chunk;
        n_nch     = r_nch;
        n_det     = r_det;
        n_prod    = r_prod;
        n_nxt     = r_nxt;
        n_pp      = r_pp;
        n_sign    = r_sign;
        n_acc     = r_acc;
        n_dz      = r_dz;
        n_dneg    = r_dneg;
        n_dmag    = r_dmag;
        n_pval    = r_pval;
        n_psing   = r_psing;
        n_psat    = r_psat;
        n_oidx    = r_oidx;
        n_oval    = r_oval;
        n_osing   = r_osing;
        n_osat    = r_osat;
        n_olast   = r_olast;
        n_ov      = r_ov && !o_res.ready;
        st_we     = 1'b0;
        cf_we     = 1'b0;
        cf_wdata  = sum[CW-1:0];
        div_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    st_we = 1'b1;
                    if (i_elem.elem_index == RUN_INDEX) begin
                        n_cell  = '0;
                        n_term  = '0;
                        n_fac   = '0;
                        n_det   = 1'b0;
                        n_acc   = '0;
                        n_state = ST_CF_FETCH;
                    end
                end
            end
            ST_CF_FETCH: begin
                // read of the next factor is in flight
                if (r_fac == '0) begin
                    n_state = ST_CF_LOAD;
                end else begin
                    n_chunk = '0;
                    n_nxt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_CF_LOAD: begin
                // first factor; sign carries the term's and the cofactor's sign
                n_prod  = XW'(emag);
                n_sign  = r_sq[W-1] ^ (r_term >= NEG_TERM) ^ r_cell[2] ^ r_cell[0];
                n_nch   = (CHW+1)'(1);
                n_fac   = 2'd1;
                n_state = ST_CF_FETCH;
            end
            ST_MUL: begin
                n_pp    = (2*W)'(chunk_w) * (2*W)'(emag);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_nxt = r_nxt + (XW'(r_pp) << (r_chunk * W));
                if ((CHW+1)'(r_chunk) + 1'b1 == r_nch) begin
                    n_state = ST_PASS;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_PASS: begin
                n_prod = r_nxt;
                n_sign = r_sign ^ r_sq[W-1];
                n_nch  = r_nch + 1'b1;
                if (r_det || r_fac == LAST_FAC) begin
                    n_state = ST_ADD;
                end else begin
                    n_fac   = r_fac + 1'b1;
                    n_state = ST_CF_FETCH;
                end
            end
            ST_ADD: begin
                if (r_det) begin
                    n_acc = sum;
                    if (r_k == LAST_DET) begin
                        n_state = ST_DT_FIN;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_DT_FETCH;
                    end
                end else if (r_term == LAST_TERM) begin
                    cf_we  = 1'b1;
                    n_acc  = '0;
                    n_term = '0;
                    n_fac  = '0;
                    if (r_cell == LAST_CELL) begin
                        n_det   = 1'b1;
                        n_k     = '0;
                        n_state = ST_DT_FETCH;
                    end else begin
                        n_cell  = r_cell + 1'b1;
                        n_state = ST_CF_FETCH;
                    end
                end else begin
                    n_acc   = sum;
                    n_term  = r_term + 1'b1;
                    n_fac   = '0;
                    n_state = ST_CF_FETCH;
                end
            end
            ST_DT_FETCH: begin
                n_state = ST_DT_LOAD;
            end
            ST_DT_LOAD: begin
                // first-row cofactor times first-row element, chunk by chunk
                n_prod  = XW'(cmag);
                n_sign  = r_cq[CW-1];
                n_nch   = (CHW+1)'(NCH);
                n_chunk = '0;
                n_nxt   = '0;
                n_state = ST_MUL;
            end
            ST_DT_FIN: begin
                n_dz    = (r_acc == '0);
                n_dneg  = r_acc[DW-1];
                n_dmag  = r_acc[DW-1] ? DW'(-r_acc) : r_acc;
                n_k     = '0;
                n_state = ST_OUT_FETCH;
            end
            ST_OUT_FETCH: begin
                n_state = ST_DV_START;
            end
            ST_DV_START: begin
                if (r_dz) begin
                    // singular: pass the stored element through
                    n_pval  = r_sq;
                    n_psing = 1'b1;
                    n_psat  = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DV_WAIT;
                end
            end
            ST_DV_WAIT: begin
                if (div_stat.done) begin
                    n_pval  = div_value;
                    n_psing = 1'b0;
                    n_psat  = div_stat.sat;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold the finished value until the output beat frees up
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_oidx  = r_k;
                    n_oval  = r_pval;
                    n_osing = r_psing;
                    n_osat  = r_psat;
                    n_olast = (r_k == LAST_CELL);
                    if (r_k == LAST_CELL) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_OUT_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell  <= n_cell;
        r_term  <= n_term;
        r_fac   <= n_fac;
        r_k     <= n_k;
        r_chunk <= n_chunk;
        r_nch   <= n_nch;
        r_det   <= n_det;
        r_prod  <= n_prod;
        r_nxt   <= n_nxt;
        r_pp    <= n_pp;
        r_sign  <= n_sign;
        r_acc   <= n_acc;
        r_dz    <= n_dz;
        r_dneg  <= n_dneg;
        r_dmag  <= n_dmag;
        r_pval  <= n_pval;
        r_psing <= n_psing;
        r_psat  <= n_psat;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_osing <= n_osing;
        r_osat  <= n_osat;
        r_olast <= n_olast;
    end

    `MI4_ASSERT_NEXT(a_run_start, i_clk, i_rst_n, in_acc && i_elem.elem_index == RUN_INDEX, r_state == ST_CF_FETCH, "index 15 did not start a run")
    `MI4_ASSERT(a_last_index, i_clk, i_rst_n, o_res.valid && o_res.last, o_res.out_index == LAST_CELL, "last beat not at index 15")
    `MI4_ASSERT(a_sing_nosat, i_clk, i_rst_n, o_res.valid && o_res.singular, !o_res.saturated, "singular beat flagged saturated")
    `MI4_ASSERT(a_div_done, i_clk, i_rst_n, div_stat.done, r_state == ST_DV_WAIT, "divider finished outside wait")

endmodule

// ===== design/mi4_divider.sv =====
// Bit-serial rounded, saturating divide of a cofactor by the determinant.
module mi4_divider
    import mi4_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [3*ELEM_WIDTH+2:0]   i_num,
    input  logic [4*ELEM_WIDTH+4:0]   i_den,
    input  logic                      i_den_neg,
    output t_div_stat                 o_stat,
    output logic [ELEM_WIDTH-1:0]     o_value
);
    localparam int W  = ELEM_WIDTH;
    localparam int CW = 3 * W + 3;
    localparam int DW = 4 * W + 5;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int RW = (NW > DW + W) ? NW : DW + W;
    localparam int BW = $clog2(W);

    t_dv_state       r_state, n_state;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_dsh, n_dsh;
    logic [W-1:0]    r_q, n_q;
    logic [BW-1:0]   r_bit, n_bit;
    logic            r_neg, n_neg;
    logic            r_ovf, n_ovf;

    logic [CW-1:0]   nmag;
    logic            ge;
    logic            rnd;
    logic [W:0]      qr;
    logic [W:0]      lim;
    logic [W:0]      mag;
    logic            sat;

    always_comb begin
        nmag = i_num[CW-1] ? CW'(-i_num) : i_num;
        ge   = (r_rem >= r_dsh);
        rnd  = ({r_rem, 1'b0} >= (RW+1)'(i_den));
        qr   = (W+1)'(r_q) + (W+1)'(rnd);
        lim  = ((W+1)'(1) << (W - 1)) - (W+1)'(!r_neg);
        sat  = r_ovf || (qr > lim);
        mag  = sat ? lim : qr;
        o_value = r_neg ? W'(-mag) : W'(mag);

        n_state = r_state;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_bit   = r_bit;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        o_stat  = '{done: 1'b0, sat: sat};
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem   = RW'(nmag) << (2 * FRAC_BITS);
                    n_dsh   = RW'(i_den) << W;
                    n_neg   = i_num[CW-1] ^ i_den_neg;
                    n_state = DV_CHK;
                end
            end
            DV_CHK: begin
                // quotient of 2^W or more always clips
                n_ovf   = ge;
                n_dsh   = r_dsh >> 1;
                n_q     = '0;
                n_bit   = BW'(W - 1);
                n_state = DV_STEP;
            end
            DV_STEP: begin
                if (ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[W-2:0], ge};
                n_dsh = r_dsh >> 1;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = DV_RND;
                end
            end
            DV_RND: begin
                o_stat.done = 1'b1;
                n_state     = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_bit <= n_bit;
        r_neg <= n_neg;
        r_ovf <= n_ovf;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the 4x4 fixed-point matrix inverse: directed and random matrices, scoreboard check.
`timescale 1ns / 100ps

module tb_top;
    import mi4_pkg::*;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_ITEMS  = 250;
    localparam int IDLE_LIMIT = 20000;   // covers the silent cofactor run; stalls add little
    localparam int DRAIN_WAIT = 60;
    localparam logic [ELEM_WIDTH-1:0] Q_ONE = 1 << FRAC_BITS;

    // Wide enough for a 4-term product of 32-bit elements shifted by 2*FRAC_BITS.
    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [3:0]            idx;
        logic [ELEM_WIDTH-1:0] val;
        bit                    drain;   // hold this beat until all results are back
    } elem_beat_t;

    typedef struct {
        logic [3:0]            idx;
        logic [ELEM_WIDTH-1:0] val;
        logic                  singular;
        logic                  saturated;
        logic                  last;
    } inv_beat_t;

    logic i_clk;
    logic i_rst_n;

    mi4_in_if  #(.ELEM_WIDTH(ELEM_WIDTH)) elem_ch ();
    mi4_out_if #(.ELEM_WIDTH(ELEM_WIDTH)) res_ch ();

    matrix_inverse_4x4 #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .o_res   (res_ch)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    elem_beat_t            pending_elems[$];
    inv_beat_t             expected_inv[$];
    logic [ELEM_WIDTH-1:0] shadow_store[16];   // predictor copy of the element store
    int                    n_errors = 0;
    int                    send_gap = 0;
    int                    recv_stall = 0;
    int                    idle_cycles = 0;

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic wide_t sext(logic [ELEM_WIDTH-1:0] e);
        logic signed [ELEM_WIDTH-1:0] s;
        wide_t w;
        s = e;
        w = s;
        return w;
    endfunction

    // Signed cofactor of entry (ri, ci) from the 3x3 minor.
    function automatic wide_t cofactor_of(wide_t el[16], int ri, int ci);
        int    rs[3];
        int    cs[3];
        int    k;
        int    n;
        wide_t m[3][3];
        wide_t d3;
        k = 0;
        n = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != ri) begin
                rs[k] = i;
                k++;
            end
            if (i != ci) begin
                cs[n] = i;
                n++;
            end
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m[a][b] = el[rs[a]*4 + cs[b]];
        d3 = m[0][0] * (m[1][1]*m[2][2] - m[1][2]*m[2][1])
           - m[0][1] * (m[1][0]*m[2][2] - m[1][2]*m[2][0])
           + m[0][2] * (m[1][0]*m[2][1] - m[1][1]*m[2][0]);
        return ((ri + ci) % 2) ? -d3 : d3;
    endfunction

    // t * 2^(2F) / d, rounded half away from zero, clipped to the element range.
    function automatic logic [ELEM_WIDTH:0] scaled_quotient(wide_t t, wide_t d);
        bit    neg;
        wide_t num;
        wide_t den;
        wide_t q;
        wide_t r;
        wide_t lim;
        logic  sat;
        neg = (t < 0) != (d < 0);
        num = (t < 0) ? -t : t;
        den = (d < 0) ? -d : d;
        num = num <<< (2*FRAC_BITS);
        q   = num / den;
        r   = num % den;
        if ((r <<< 1) >= den) q = q + 1;
        lim = (wide_t'(1) <<< (ELEM_WIDTH-1)) - (neg ? 0 : 1);
        sat = 1'b0;
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        if (neg) q = -q;
        return {sat, q[ELEM_WIDTH-1:0]};
    endfunction

    // Store the element; on index 15 queue the sixteen inverse beats.
    task automatic predict_inverse(logic [3:0] idx, logic [ELEM_WIDTH-1:0] val);
        wide_t               el[16];
        wide_t               cof[4][4];
        wide_t               det;
        inv_beat_t           b;
        logic [ELEM_WIDTH:0] qs;
        shadow_store[idx] = val;
        if (idx != RUN_INDEX) return;
        for (int i = 0; i < 16; i++) el[i] = sext(shadow_store[i]);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = cofactor_of(el, i, j);
        det = 0;
        for (int j = 0; j < 4; j++) det = det + el[j] * cof[0][j];
        for (int k = 0; k < 16; k++) begin
            b.idx  = 4'(k);
            b.last = (k == 15);
            if (det == 0) begin
                b.val       = shadow_store[k];
                b.singular  = 1'b1;
                b.saturated = 1'b0;
            end else begin
                // adjugate (r, c) is the cofactor of (c, r)
                qs          = scaled_quotient(cof[k % 4][k / 4], det);
                b.val       = qs[ELEM_WIDTH-1:0];
                b.singular  = 1'b0;
                b.saturated = qs[ELEM_WIDTH];
            end
            expected_inv.push_back(b);
        end
    endtask

    task automatic queue_elem(int idx, logic [ELEM_WIDTH-1:0] val, bit drain = 0);
        elem_beat_t e;
        e.idx   = 4'(idx);
        e.val   = val;
        e.drain = drain;
        pending_elems.push_back(e);
    endtask

    // Random element: mostly modest Q16.16 values, some full-range bit patterns.
    function automatic logic [ELEM_WIDTH-1:0] rand_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        if (r < 8) return $urandom;
        if (r < 9) return 0;
        return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
    endfunction

    // Input side: feeds pending beats, predicts each accepted beat.
    always @(posedge i_clk) begin
        elem_beat_t nb;
        logic       nv;
        if (!i_rst_n) begin
            elem_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (elem_ch.valid && elem_ch.ready)
                predict_inverse(elem_ch.elem_index, elem_ch.elem_value);
            if (!elem_ch.valid || elem_ch.ready) begin
                nv = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_elems.size() > 0 &&
                             !(pending_elems[0].drain && expected_inv.size() > 0)) begin
                    nb = pending_elems.pop_front();
                    nv = 1'b1;
                    elem_ch.elem_index <= nb.idx;
                    elem_ch.elem_value <= nb.val;
                    send_gap = pick_gap();
                end
                elem_ch.valid <= nv;
            end
        end
    end

    // Output side: random backpressure and scoreboard compare.
    always @(posedge i_clk) begin
        inv_beat_t e;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_inv.size() == 0) begin
                    $error("unexpected result beat, index %0d", res_ch.out_index);
                    n_errors++;
                end else begin
                    e = expected_inv.pop_front();
                    if (res_ch.out_index !== e.idx) begin
                        $error("out_index: expected %0d, got %0d", e.idx, res_ch.out_index);
                        n_errors++;
                    end
                    if (res_ch.out_value !== e.val) begin
                        $error("out_value: expected %h, got %h", e.val, res_ch.out_value);
                        n_errors++;
                    end
                    if (res_ch.singular !== e.singular) begin
                        $error("singular: expected %b, got %b", e.singular, res_ch.singular);
                        n_errors++;
                    end
                    if (res_ch.saturated !== e.saturated) begin
                        $error("saturated: expected %b, got %b", e.saturated,
                               res_ch.saturated);
                        n_errors++;
                    end
                    if (res_ch.last !== e.last) begin
                        $error("last: expected %b, got %b", e.last, res_ch.last);
                        n_errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // Watchdog: any accepted beat on either side resets the count.
    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [ELEM_WIDTH-1:0] m[16];
        int                    order[15];
        int                    n_items;
        int                    mode;
        int                    k;
        int                    j;
        int                    tmp;

        elem_ch.valid      = 1'b0;
        elem_ch.elem_index = '0;
        elem_ch.elem_value = '0;
        res_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;

        // Directed: full load of diag(2,2,2,2) so no entry is read unwritten.
        for (int i = 0; i < 16; i++) queue_elem(i, (i % 5 == 0) ? 2 * Q_ONE : '0);
        // Zero the top-left corner: first row all zero, singular pass-through.
        queue_elem(0, '0);
        queue_elem(15, 2 * Q_ONE);
        // Tiny diagonal entries: inverse clips high and low.
        queue_elem(0, 32'h0000_0001);
        queue_elem(15, 32'hFFFF_FFFF, 1);
        // Extreme element values on the diagonal.
        queue_elem(0, 32'h7FFF_FFFF);
        queue_elem(5, 32'h8000_0000);
        queue_elem(15, 32'h8000_0000);
        n_items = 23;

        // Random: mostly full matrices in shuffled order, also partial edits and noise.
        while (n_items < NUM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                for (int i = 0; i < 16; i++) m[i] = rand_elem();
                if ($urandom_range(0, 9) == 0)
                    for (int c = 0; c < 4; c++) m[4 + c] = m[c];   // repeated row
                for (int i = 0; i < 15; i++) order[i] = i;
                for (int i = 14; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < 15; i++) queue_elem(order[i], m[order[i]]);
                queue_elem(15, m[15], $urandom_range(0, 4) == 0);
                n_items += 16;
            end else if (mode < 9) begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) queue_elem($urandom_range(0, 14), rand_elem());
                queue_elem(15, rand_elem(), $urandom_range(0, 1) == 1);
                n_items += k + 1;
            end else begin
                // stray stores with no run; picked up by a later matrix
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) queue_elem($urandom_range(0, 14), $urandom);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_elems.size() > 0 || elem_ch.valid || expected_inv.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && expected_inv.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
